>>> sv/tov_pkg.sv
`default_nettype none

package tov_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_BITS = 3;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_REF_X0 = 3'd0;
    localparam t_cfg_idx REG_REF_Y0 = 3'd1;
    localparam t_cfg_idx REG_REF_X1 = 3'd2;
    localparam t_cfg_idx REG_REF_Y1 = 3'd3;
    localparam t_cfg_idx REG_REF_X2 = 3'd4;
    localparam t_cfg_idx REG_REF_Y2 = 3'd5;

    // Number of vertices in a triangle.
    localparam int unsigned NUM_VERT = 3;

    // Result word, overlaps in the lowest bit.
    typedef struct packed {
        logic [2:0] query_in_ref;
        logic [2:0] ref_in_query;
        logic       boxes_overlap;
        logic       overlaps;
    } t_result;

    localparam int unsigned RES_BITS = $bits(t_result);

endpackage

`default_nettype wire

>>> sv/tov_lane.sv
`default_nettype none

// One point-in-triangle test, three pipeline stages:
// differences and bounding box, products, edge signs.
module tov_lane
    import tov_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic signed [COORD_BITS-1:0] i_px,
    input  wire logic signed [COORD_BITS-1:0] i_py,
    input  wire logic signed [COORD_BITS-1:0] i_tx [NUM_VERT],
    input  wire logic signed [COORD_BITS-1:0] i_ty [NUM_VERT],
    output logic                              o_inside
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int VW = PW + 1;

    function automatic logic signed [DW-1:0] sx(input logic signed [COORD_BITS-1:0] v);
        return {v[COORD_BITS-1], v};
    endfunction

    logic signed [DW-1:0] n_d0 [NUM_VERT];
    logic signed [DW-1:0] n_d1 [NUM_VERT];
    logic signed [DW-1:0] n_d2 [NUM_VERT];
    logic signed [DW-1:0] n_d3 [NUM_VERT];
    logic signed [DW-1:0] r_d0 [NUM_VERT];
    logic signed [DW-1:0] r_d1 [NUM_VERT];
    logic signed [DW-1:0] r_d2 [NUM_VERT];
    logic signed [DW-1:0] r_d3 [NUM_VERT];
    logic signed [PW-1:0] r_p0 [NUM_VERT];
    logic signed [PW-1:0] r_p1 [NUM_VERT];
    logic signed [VW-1:0] n_v  [NUM_VERT];
    logic [NUM_VERT-1:0]  n_flag;
    logic                 n_bb;
    logic                 r_bb1;
    logic                 r_bb2;
    logic                 r_inside;

    // Edge e runs from vertex e to vertex e+1; differences against its end point.
    for (genvar e = 0; e < NUM_VERT; e++) begin : g_edge
        localparam int B = (e + 1) % NUM_VERT;

        always_comb begin
            n_d0[e] = sx(i_px)    - sx(i_tx[B]);
            n_d1[e] = sx(i_ty[e]) - sx(i_ty[B]);
            n_d2[e] = sx(i_tx[e]) - sx(i_tx[B]);
            n_d3[e] = sx(i_py)    - sx(i_ty[B]);
        end

        // Edge value and its flag, set when the value is not positive.
        always_comb begin
            n_v[e]    = {r_p0[e][PW-1], r_p0[e]} - {r_p1[e][PW-1], r_p1[e]};
            n_flag[e] = n_v[e][VW-1] || (n_v[e] == '0);
        end
    end

    // Point within the bounding box, edges inclusive.
    always_comb begin
        n_bb = (i_px >= i_tx[0] || i_px >= i_tx[1] || i_px >= i_tx[2]) &&
               (i_px <= i_tx[0] || i_px <= i_tx[1] || i_px <= i_tx[2]) &&
               (i_py >= i_ty[0] || i_py >= i_ty[1] || i_py >= i_ty[2]) &&
               (i_py <= i_ty[0] || i_py <= i_ty[1] || i_py <= i_ty[2]);
    end

    // Stage 1: differences.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0  <= n_d0;
            r_d1  <= n_d1;
            r_d2  <= n_d2;
            r_d3  <= n_d3;
            r_bb1 <= n_bb;
        end
    end

    // Stage 2: cross products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int e = 0; e < NUM_VERT; e++) begin
                r_p0[e] <= r_d0[e] * r_d1[e];
                r_p1[e] <= r_d2[e] * r_d3[e];
            end
            r_bb2 <= r_bb1;
        end
    end

    // Stage 3: inside when the point is in the box and all three flags agree.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inside <= r_bb2 && (n_flag[0] == n_flag[1]) && (n_flag[1] == n_flag[2]);
        end
    end

    assign o_inside = r_inside;

endmodule

`default_nettype wire

>>> sv/tov_box.sv
`default_nettype none

// Bounding-box overlap of the two triangles, delayed to match the lanes.
module tov_box
    import tov_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic signed [COORD_BITS-1:0] i_ax [NUM_VERT],
    input  wire logic signed [COORD_BITS-1:0] i_ay [NUM_VERT],
    input  wire logic signed [COORD_BITS-1:0] i_bx [NUM_VERT],
    input  wire logic signed [COORD_BITS-1:0] i_by [NUM_VERT],
    output logic                              o_box
);

    function automatic logic signed [COORD_BITS-1:0] min3(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b,
        input logic signed [COORD_BITS-1:0] c
    );
        logic signed [COORD_BITS-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] max3(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b,
        input logic signed [COORD_BITS-1:0] c
    );
        logic signed [COORD_BITS-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic n_box;
    logic r_box1;
    logic r_box2;
    logic r_box3;

    // Boxes overlap when each range reaches the other on both axes.
    always_comb begin
        n_box = (min3(i_ax[0], i_ax[1], i_ax[2]) <= max3(i_bx[0], i_bx[1], i_bx[2])) &&
                (max3(i_ax[0], i_ax[1], i_ax[2]) >= min3(i_bx[0], i_bx[1], i_bx[2])) &&
                (min3(i_ay[0], i_ay[1], i_ay[2]) <= max3(i_by[0], i_by[1], i_by[2])) &&
                (max3(i_ay[0], i_ay[1], i_ay[2]) >= min3(i_by[0], i_by[1], i_by[2]));
    end

    // Three stages to line up with the lane results.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_box1 <= n_box;
            r_box2 <= r_box1;
            r_box3 <= r_box2;
        end
    end

    assign o_box = r_box3;

endmodule

`default_nettype wire

>>> sv/tov_merge.sv
`default_nettype none

// Combines the lane results and holds the output word.
module tov_merge
    import tov_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_vld,
    input  wire logic                i_box,
    input  wire logic [NUM_VERT-1:0] i_rin,
    input  wire logic [NUM_VERT-1:0] i_qin,
    input  wire logic                i_ready,
    output logic                     o_en,
    output logic                     o_valid,
    output t_result                  o_res
);

    logic    r_valid;
    t_result r_res;
    t_result n_res;

    // The pipeline advances whenever the output register is free or drained.
    assign o_en = !r_valid || i_ready;

    always_comb begin
        n_res.overlaps      = i_box && ((i_rin | i_qin) != '0);
        n_res.boxes_overlap = i_box;
        n_res.ref_in_query  = i_rin;
        n_res.query_in_ref  = i_qin;
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_vld;
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> sv/triangle_overlap_test.sv
// Pipeline: each accepted word passes through the lane stages and then the output register.
// Throughput: one word per cycle unless stalled; six point-in-triangle lanes and a box unit run in parallel.
// The pipeline stalls as a whole only while the output word waits to be taken.
// Reset (synchronous, active low) clears the reference triangle to all zeros
// and empties the pipeline.
`default_nettype none

module triangle_overlap_test
    import tov_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_idx              i_cfg_idx,
    input  wire logic [COORD_BITS-1:0] i_cfg_data,
    // Query stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: qry_x0, qry_y0, qry_x1, qry_y1, qry_x2, qry_y2, zero fill.
    input  wire logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Result stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0: overlaps, boxes_overlap, ref_in_query[2:0], query_in_ref[2:0].
    output logic [RES_BITS-1:0]        m_axis_tdata
);

    logic signed [COORD_BITS-1:0] r_ref_x [NUM_VERT];
    logic signed [COORD_BITS-1:0] r_ref_y [NUM_VERT];
    logic signed [COORD_BITS-1:0] qry_x   [NUM_VERT];
    logic signed [COORD_BITS-1:0] qry_y   [NUM_VERT];
    logic [2:0]                   r_vld;
    logic                         en;
    logic                         box;
    logic [NUM_VERT-1:0]          rin;
    logic [NUM_VERT-1:0]          qin;
    t_result                      res;

    // Reference triangle registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VERT; i++) begin
                r_ref_x[i] <= '0;
                r_ref_y[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REF_X0: r_ref_x[0] <= i_cfg_data;
                REG_REF_Y0: r_ref_y[0] <= i_cfg_data;
                REG_REF_X1: r_ref_x[1] <= i_cfg_data;
                REG_REF_Y1: r_ref_y[1] <= i_cfg_data;
                REG_REF_X2: r_ref_x[2] <= i_cfg_data;
                REG_REF_Y2: r_ref_y[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the query vertices.
    always_comb begin
        for (int i = 0; i < NUM_VERT; i++) begin
            qry_x[i] = s_axis_tdata[(2*i)*COORD_BITS +: COORD_BITS];
            qry_y[i] = s_axis_tdata[(2*i+1)*COORD_BITS +: COORD_BITS];
        end
    end

    // Valid bits of the three lane stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[1:0], s_axis_tvalid};
        end
    end

    assign s_axis_tready = en;

    // Reference vertices against the query triangle, and the reverse.
    for (genvar i = 0; i < NUM_VERT; i++) begin : g_lane
        tov_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_ref_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_px     (r_ref_x[i]),
            .i_py     (r_ref_y[i]),
            .i_tx     (qry_x),
            .i_ty     (qry_y),
            .o_inside (rin[i])
        );

        tov_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_qry_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_px     (qry_x[i]),
            .i_py     (qry_y[i]),
            .i_tx     (r_ref_x),
            .i_ty     (r_ref_y),
            .o_inside (qin[i])
        );
    end

    tov_box #(
        .COORD_BITS (COORD_BITS)
    ) u_box (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ax  (r_ref_x),
        .i_ay  (r_ref_y),
        .i_bx  (qry_x),
        .i_by  (qry_y),
        .o_box (box)
    );

    tov_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[2]),
        .i_box   (box),
        .i_rin   (rin),
        .i_qin   (qin),
        .i_ready (m_axis_tready),
        .o_en    (en),
        .o_valid (m_axis_tvalid),
        .o_res   (res)
    );

    assign m_axis_tdata = res;

endmodule

`default_nettype wire

>>> test/tb_triangle_overlap_test.sv
`timescale 1ns / 100ps

module tb_triangle_overlap_test;
    import tov_pkg::*;

    localparam int COORD_BITS       = 16;
    localparam int QRY_BITS         = ((6*COORD_BITS+7)/8)*8;
    localparam int COORD_MIN        = -(2**(COORD_BITS-1));
    localparam int COORD_MAX        = 2**(COORD_BITS-1) - 1;
    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 200;
    localparam int LONG_HOLD_CYCLES = 40;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int MAX_REPORTS      = 10;

    // Register indexes that the block does not decode; writes to them are dropped.
    localparam t_cfg_idx REG_SPARE_6 = 3'd6;
    localparam t_cfg_idx REG_SPARE_7 = 3'd7;

    typedef logic [COORD_BITS-1:0] t_coord;

    // One query word, qry_x0 in the lowest bits.
    typedef struct packed {
        t_coord y2;
        t_coord x2;
        t_coord y1;
        t_coord x1;
        t_coord y0;
        t_coord x0;
    } t_query;

    // Holds the reference triangle, predicts each result word and checks it in order.
    class overlap_scoreboard;
        t_coord  tri_x[3];
        t_coord  tri_y[3];
        t_result expected_results[$];
        int      mismatches;

        function new();
            int i;
            for (i = 0; i < 3; i++) begin
                tri_x[i] = '0;
                tri_y[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void store_reg(t_cfg_idx idx, t_coord value);
            case (idx)
                REG_REF_X0: tri_x[0] = value;
                REG_REF_Y0: tri_y[0] = value;
                REG_REF_X1: tri_x[1] = value;
                REG_REF_Y1: tri_y[1] = value;
                REG_REF_X2: tri_x[2] = value;
                REG_REF_Y2: tri_y[2] = value;
                default: ;
            endcase
        endfunction

        function longint lo3(longint v[3]);
            longint m;
            m = v[0] < v[1] ? v[0] : v[1];
            return m < v[2] ? m : v[2];
        endfunction

        function longint hi3(longint v[3]);
            longint m;
            m = v[0] > v[1] ? v[0] : v[1];
            return m > v[2] ? m : v[2];
        endfunction

        // A point is inside when it is in the box and the edge flags all agree.
        function bit vertex_inside(longint tx[3], longint ty[3], longint px, longint py);
            bit     flag[3];
            longint v;
            int     j;
            int     k;
            if (px < lo3(tx) || px > hi3(tx) || py < lo3(ty) || py > hi3(ty))
                return 1'b0;
            for (j = 0; j < 3; j++) begin
                k = (j + 1) % 3;
                v = (px - tx[k]) * (ty[j] - ty[k]) - (tx[j] - tx[k]) * (py - ty[k]);
                flag[j] = (v <= 0);
            end
            return flag[0] == flag[1] && flag[1] == flag[2];
        endfunction

        function t_result predict_overlap(t_query q);
            longint  ax[3], ay[3], bx[3], by[3];
            t_result r;
            int      i;
            for (i = 0; i < 3; i++) begin
                ax[i] = longint'($signed(tri_x[i]));
                ay[i] = longint'($signed(tri_y[i]));
            end
            bx[0] = longint'($signed(q.x0));
            by[0] = longint'($signed(q.y0));
            bx[1] = longint'($signed(q.x1));
            by[1] = longint'($signed(q.y1));
            bx[2] = longint'($signed(q.x2));
            by[2] = longint'($signed(q.y2));
            r = '0;
            r.boxes_overlap = lo3(ax) <= hi3(bx) && hi3(ax) >= lo3(bx) &&
                              lo3(ay) <= hi3(by) && hi3(ay) >= lo3(by);
            for (i = 0; i < 3; i++) begin
                r.ref_in_query[i] = vertex_inside(bx, by, ax[i], ay[i]);
                r.query_in_ref[i] = vertex_inside(ax, ay, bx[i], by[i]);
            end
            r.overlaps = r.boxes_overlap && (r.ref_in_query != 0 || r.query_in_ref != 0);
            return r;
        endfunction

        function void note_query(t_query q);
            expected_results.push_back(predict_overlap(q));
        endfunction

        function void note_mismatch(string field, logic [7:0] want, logic [7:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: mismatch in %s, expected %0h, got %0h", $time, field, want, got);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected word", 8'h0, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.overlaps !== want.overlaps)
                note_mismatch("overlaps", want.overlaps, got.overlaps);
            if (got.boxes_overlap !== want.boxes_overlap)
                note_mismatch("boxes_overlap", want.boxes_overlap, got.boxes_overlap);
            if (got.ref_in_query !== want.ref_in_query)
                note_mismatch("ref_in_query", want.ref_in_query, got.ref_in_query);
            if (got.query_in_ref !== want.query_in_ref)
                note_mismatch("query_in_ref", want.query_in_ref, got.query_in_ref);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    t_coord              i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // Fields from bit 0: qry_x0, qry_y0, qry_x1, qry_y1, qry_x2, qry_y2.
    logic [QRY_BITS-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // Fields from bit 0: overlaps, boxes_overlap, ref_in_query[2:0], query_in_ref[2:0].
    logic [RES_BITS-1:0] m_axis_tdata;

    overlap_scoreboard sb;

    // Traffic shaping shared between the sender and the receiver.
    bit hold_request = 1'b0;
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int idle_cycles  = 0;

    // Current reference triangle, used only to aim the random queries.
    longint anchor_x[3] = '{0, 0, 0};
    longint anchor_y[3] = '{0, 0, 0};

    triangle_overlap_test #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Record every accepted query and check every accepted result word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_query(t_query'(s_axis_tdata[$bits(t_query)-1:0]));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(t_result'(m_axis_tdata));
        end
    end

    // End the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : receiver
        int n;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                n = $urandom_range(1, 18);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic longint rand_in(longint lo, longint hi);
        return lo + longint'($urandom) % (hi - lo + 1);
    endfunction

    function automatic int rand_coord();
        return int'($signed(t_coord'($urandom)));
    endfunction

    function automatic t_coord clamp_coord(longint v);
        if (v < COORD_MIN)
            return t_coord'(COORD_MIN);
        if (v > COORD_MAX)
            return t_coord'(COORD_MAX);
        return t_coord'(v);
    endfunction

    // Random query, mostly aimed at the reference triangle so that the inside
    // tests see hits, edges and near misses as well as plain noise.
    function automatic t_query make_query();
        t_query q;
        longint px[3], py[3];
        longint lo_x, hi_x, lo_y, hi_y, mx, my, dx, dy, cx, cy, k;
        int     kind, i, v;
        lo_x = anchor_x[0];
        hi_x = anchor_x[0];
        lo_y = anchor_y[0];
        hi_y = anchor_y[0];
        for (i = 1; i < 3; i++) begin
            if (anchor_x[i] < lo_x) lo_x = anchor_x[i];
            if (anchor_x[i] > hi_x) hi_x = anchor_x[i];
            if (anchor_y[i] < lo_y) lo_y = anchor_y[i];
            if (anchor_y[i] > hi_y) hi_y = anchor_y[i];
        end
        mx = (hi_x - lo_x) / 4 + 8;
        my = (hi_y - lo_y) / 4 + 8;
        cx = (anchor_x[0] + anchor_x[1] + anchor_x[2]) / 3;
        cy = (anchor_y[0] + anchor_y[1] + anchor_y[2]) / 3;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            q = {$urandom, $urandom, $urandom};
            return q;
        end
        dx = rand_in(-mx, mx);
        dy = rand_in(-my, my);
        for (i = 0; i < 3; i++) begin
            v = $urandom_range(0, 2);
            if (kind < 45) begin
                // Anywhere in or around the reference box.
                px[i] = rand_in(lo_x - mx, hi_x + mx);
                py[i] = rand_in(lo_y - my, hi_y + my);
            end else if (kind < 60) begin
                // Close to a reference vertex.
                px[i] = anchor_x[v] + rand_in(-4, 4);
                py[i] = anchor_y[v] + rand_in(-4, 4);
            end else if (kind < 84 && i == 0) begin
                px[0] = rand_in(lo_x - mx, hi_x + mx);
                py[0] = rand_in(lo_y - my, hi_y + my);
            end else if (kind < 72) begin
                // Single point query.
                px[i] = px[0];
                py[i] = py[0];
            end else if (kind < 84) begin
                // Collinear query along one random direction.
                k = rand_in(-2, 2);
                px[i] = px[0] + dx * k;
                py[i] = py[0] + dy * k;
            end else if (kind < 92) begin
                // Huge triangle spanning most of the plane.
                if (i == 0) begin
                    px[i] = rand_in(COORD_MIN, COORD_MIN + 2000);
                    py[i] = rand_in(COORD_MIN, COORD_MIN + 2000);
                end else if (i == 1) begin
                    px[i] = rand_in(COORD_MAX - 2000, COORD_MAX);
                    py[i] = rand_in(COORD_MIN, COORD_MIN + 2000);
                end else begin
                    px[i] = rand_in(-2000, 2000);
                    py[i] = rand_in(COORD_MAX - 2000, COORD_MAX);
                end
            end else begin
                // Reference pulled toward its centroid, so mostly inside it.
                px[i] = (3 * anchor_x[i] + cx) / 4 + rand_in(-1, 1);
                py[i] = (3 * anchor_y[i] + cy) / 4 + rand_in(-1, 1);
            end
        end
        q.x0 = clamp_coord(px[0]);
        q.y0 = clamp_coord(py[0]);
        q.x1 = clamp_coord(px[1]);
        q.y1 = clamp_coord(py[1]);
        q.x2 = clamp_coord(px[2]);
        q.y2 = clamp_coord(py[2]);
        return q;
    endfunction

    task automatic cfg_write(input t_cfg_idx idx, input t_coord value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.store_reg(idx, value);
    endtask

    // Loads a new reference triangle; the block must be idle.
    task automatic load_triangle(input int x0, y0, x1, y1, x2, y2, input bit spare_writes);
        cfg_write(REG_REF_X0, t_coord'(x0));
        cfg_write(REG_REF_Y0, t_coord'(y0));
        cfg_write(REG_REF_X1, t_coord'(x1));
        cfg_write(REG_REF_Y1, t_coord'(y1));
        cfg_write(REG_REF_X2, t_coord'(x2));
        cfg_write(REG_REF_Y2, t_coord'(y2));
        if (spare_writes) begin
            cfg_write(REG_SPARE_6, t_coord'($urandom));
            cfg_write(REG_SPARE_7, t_coord'($urandom));
        end
        i_cfg_we <= 1'b0;
        anchor_x[0] = x0;
        anchor_y[0] = y0;
        anchor_x[1] = x1;
        anchor_y[1] = y1;
        anchor_x[2] = x2;
        anchor_y[2] = y2;
    endtask

    // Offers one query word and returns at the edge where it is taken.
    task automatic send_query(input t_query q);
        s_axis_tdata  <= q;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    task automatic send_tri(input int x0, y0, x1, y1, x2, y2);
        t_query q;
        q.x0 = t_coord'(x0);
        q.y0 = t_coord'(y0);
        q.x1 = t_coord'(x1);
        q.y1 = t_coord'(y1);
        q.x2 = t_coord'(x2);
        q.y2 = t_coord'(y2);
        send_query(q);
    endtask

    task automatic sender_gap(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin : stimulus
        int ph;
        int cxr;
        int cyr;
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_REF_X0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reference still at its reset value: a single point at the origin.
        send_tri(-10, -10, 10, -10, 0, 10);
        send_tri(0, 0, 0, 0, 0, 0);
        send_tri(5, 5, 9, 5, 5, 9);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Directed queries against a medium counterclockwise triangle.
        load_triangle(-1000, -1000, 1000, -1000, 0, 1000, 1'b0);
        send_tri(0, 0, 0, 0, 0, 0);
        send_tri(-1000, -1000, -1000, -1000, -1000, -1000);
        send_tri(0, -1000, 0, -1000, 0, -1000);
        send_tri(900, 900, 900, 900, 900, 900);
        send_tri(5000, 5000, 5000, 5000, 5000, 5000);
        send_tri(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 0, COORD_MAX);
        send_tri(-10, -10, 10, -10, 0, 10);
        send_tri(-1000, -1000, 1000, -1000, 0, 1000);
        send_tri(-1000, -1000, 0, 1000, 1000, -1000);
        // Star shape: the edges cross but no vertex lies inside the other triangle.
        send_tri(-1000, 600, 1000, 600, 0, -1400);
        send_tri(-2000, 0, 0, 0, 2000, 0);
        send_tri(0, -2000, 0, -1000, 0, 3000);
        send_tri(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_tri(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_tri(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_tri(1000, -1000, 2000, -1000, 1500, -2000);
        send_tri(1000, 1000, 2000, 1000, 1500, 2000);
        s_axis_tvalid <= 1'b0;

        // Random phases, each with its own reference triangle and traffic pattern.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: load_triangle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                 COORD_MIN, COORD_MAX, 1'b1);
                1: load_triangle(100, 100, 100, 400, 400, 100, 1'b0);
                2: load_triangle(-500, -500, 0, 0, 500, 500, 1'b0);
                3: load_triangle(1234, -4321, 1234, -4321, 1234, -4321, 1'b1);
                5: load_triangle(-20000, 3, 20000, -3, 0, 5, 1'b0);
                6: begin
                    cxr = rand_coord() / 2;
                    cyr = rand_coord() / 2;
                    load_triangle(cxr + $urandom_range(0, 4000) - 2000,
                                  cyr + $urandom_range(0, 4000) - 2000,
                                  cxr + $urandom_range(0, 4000) - 2000,
                                  cyr + $urandom_range(0, 4000) - 2000,
                                  cxr + $urandom_range(0, 4000) - 2000,
                                  cyr + $urandom_range(0, 4000) - 2000, 1'b1);
                end
                default: load_triangle(rand_coord(), rand_coord(), rand_coord(),
                                       rand_coord(), rand_coord(), rand_coord(), 1'b0);
            endcase
            if (ph == NUM_PHASES - 1) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = (ph % 3) * 12;
                rx_stall_pct = ((ph + 1) % 3) * 12;
            end
            // The first phase opens with a long receiver hold-off to fill the pipeline.
            if (ph == 0)
                hold_request = 1'b1;
            repeat (ITEMS_PER_PHASE) begin
                send_query(make_query());
                if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct)
                    sender_gap($urandom_range(1, 18));
            end
            s_axis_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/tov_pkg.sv
sv/tov_lane.sv
sv/tov_box.sv
sv/tov_merge.sv
sv/triangle_overlap_test.sv
test/tb_triangle_overlap_test.sv
